FILE: hdl/brlr_pkg.sv
// Shared types and constants for the Bresenham line raster core.
// Used by brlr_ctrl, brlr_dp and bresenham_line_raster_core; no dependencies.
`default_nettype none

package brlr_pkg;

	localparam int COORD_BITS = 5;
	localparam int DEC_BITS   = COORD_BITS + 3;

	localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;

	// octant cases
	localparam logic [1:0] OCT_X_RISE = 2'd0;
	localparam logic [1:0] OCT_Y_RISE = 2'd1;
	localparam logic [1:0] OCT_X_FALL = 2'd2;
	localparam logic [1:0] OCT_Y_FALL = 2'd3;

	typedef struct packed {
		logic load;  // capture a new segment
		logic emit;  // move current pixel to output register and advance
	} dp_cmd_t;

	typedef struct packed {
		logic at_last;  // current pixel is the segment end
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: hdl/bresenham_line_raster_core.sv
// Top level of the Bresenham line raster core: stream ports, controller, datapath.
// Depends on brlr_pkg, brlr_ctrl and brlr_dp.
`default_nettype none

// Takes one line segment per input transaction (two grid endpoints) and
// streams out every grid pixel from start to end inclusive, one pixel per
// output transaction, with tlast on the final pixel. If the first endpoint
// lies right of the second, the endpoints are swapped, so pixels always run
// with x non-decreasing. Diagonal ties walk x-major. Timing: the segment is
// first captured and set up, then one pixel per cycle comes from the decision
// walk unit while the output side keeps up; a segment has N pixels
// (N = max(dx,|dy|)+1, up to 32). A new segment is taken
// as soon as the last pixel of the previous one has moved into the output
// register, even if that pixel has not yet been taken downstream.
module bresenham_line_raster_core
	import brlr_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// start_x, start_y, end_x, end_y (from bit 0 up), zero padded
	input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// pixel_x, pixel_y (from bit 0 up), zero padded
	output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
	output logic                          m_axis_tlast
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	coord_t  pixel_x, pixel_y;

	brlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	brlr_dp u_dp (
		.clk        (clk),
		.start_x    (s_axis_tdata[COORD_BITS-1:0]),
		.start_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.end_x      (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.end_y      (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
		.cmd        (cmd),
		.sts        (sts),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (m_axis_tlast)
	);

	// pack result; upper pad bits are zero
	assign m_axis_tdata = OUT_DATA_BITS'({pixel_y, pixel_x});

endmodule

`default_nettype wire

FILE: hdl/brlr_ctrl.sv
// Controller FSM for the line raster core: handshakes and walk sequencing.
// Depends on brlr_pkg.
`default_nettype none

module brlr_ctrl
	import brlr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic state_q;
	logic out_valid_q;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.load = in_valid && in_ready;
		cmd.emit = (state_q == ST_WALK) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (cmd.emit && sts.at_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/brlr_dp.sv
// Datapath for the line raster core: segment setup, decision walk, output register.
// Depends on brlr_pkg.
`default_nettype none

module brlr_dp
	import brlr_pkg::*;
(
	input  wire logic    clk,
	input  wire coord_t  start_x,
	input  wire coord_t  start_y,
	input  wire coord_t  end_x,
	input  wire coord_t  end_y,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts,
	output coord_t       pixel_x,
	output coord_t       pixel_y,
	output logic         last_pixel
);

	coord_t     walk_x_q, walk_y_q, stop_q;
	dec_t       dec_q, step_str_q, step_dia_q;
	logic [1:0] oct_q;
	coord_t     px_q, py_q;
	logic       plast_q;

	// setup
	coord_t                     ax, ay, bx, by, dx, rise, run, minor;
	logic signed [COORD_BITS:0] dy;
	logic [1:0]                 oct_n;
	dec_t                       run_e, minor2;

	always_comb begin
		if (start_x > end_x) begin
			ax = end_x;   ay = end_y;
			bx = start_x; by = start_y;
		end else begin
			ax = start_x; ay = start_y;
			bx = end_x;   by = end_y;
		end
		dx   = bx - ax;
		dy   = $signed({1'b0, by}) - $signed({1'b0, ay});
		rise = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		if (!dy[COORD_BITS]) begin
			oct_n = (rise <= dx) ? OCT_X_RISE : OCT_Y_RISE;
		end else begin
			oct_n = (rise <= dx) ? OCT_X_FALL : OCT_Y_FALL;
		end
		run    = oct_n[0] ? rise : dx;
		minor  = oct_n[0] ? dx : rise;
		run_e  = dec_t'({3'b000, run});
		minor2 = dec_t'({2'b00, minor, 1'b0});
	end

	// walk
	logic   major_x, diag, up;
	coord_t major;

	always_comb begin
		major_x     = !oct_q[0];
		major       = major_x ? walk_x_q : walk_y_q;
		sts.at_last = (major == stop_q);
		diag        = !dec_q[DEC_BITS-1];
		up          = !oct_q[1];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			walk_x_q   <= ax;
			walk_y_q   <= ay;
			oct_q      <= oct_n;
			stop_q     <= oct_n[0] ? by : bx;
			dec_q      <= minor2 - run_e;
			step_str_q <= minor2;
			step_dia_q <= minor2 - (run_e <<< 1);
		end else if (cmd.emit) begin
			px_q    <= walk_x_q;
			py_q    <= walk_y_q;
			plast_q <= sts.at_last;
			dec_q   <= dec_q + (diag ? step_dia_q : step_str_q);
			if (major_x || diag) begin
				walk_x_q <= walk_x_q + 1'b1;
			end
			if (!major_x || diag) begin
				walk_y_q <= up ? walk_y_q + 1'b1 : walk_y_q - 1'b1;
			end
		end
	end

	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign last_pixel = plast_q;

endmodule

`default_nettype wire
